@@ sv/dsa_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// dsa_pkg
// Shared widths, types and controller/datapath command words for the D'Hondt
// seat allocator.
// -----------------------------------------------------------------------------
package dsa_pkg;

  localparam int PARTIES    = 5;
  localparam int MAX_SEATS  = 255;
  localparam int VOTE_W     = 24;
  localparam int SEAT_IN_W  = 8;
  localparam int SEAT_OUT_W = 8;

  // seat counters hold 0..MAX_SEATS, divisors reach MAX_SEATS + 1
  localparam int SEAT_CNT_W = $clog2(MAX_SEATS + 1);
  localparam int DIVISOR_W  = $clog2(MAX_SEATS + 2);
  localparam int PIDX_W     = (PARTIES > 1) ? $clog2(PARTIES) : 1;
  localparam int DIV_CNT_W  = $clog2(VOTE_W + 1);

  typedef logic [VOTE_W-1:0]     vote_t;
  typedef logic [SEAT_CNT_W-1:0] seat_cnt_t;
  typedef logic [DIVISOR_W-1:0]  divisor_t;
  typedef logic [PIDX_W-1:0]     party_idx_t;
  typedef logic [SEAT_OUT_W-1:0] seat_out_t;

  typedef vote_t     vote_vec_t [PARTIES];
  typedef seat_out_t seat_vec_t [PARTIES];

  typedef struct packed {
    logic load;      // capture a new word, clear seat counts
    logic pick;      // award the next seat to the largest quotient
    logic div_load;  // prime the divider with the winner's votes and divisor
    logic div_step;  // one restoring division step
    logic write;     // store the new quotient of the winner
  } dsa_cmd_t;

  typedef struct packed {
    logic seats_zero;  // no seats left to award
    logic div_last;    // the current division step is the final one
  } dsa_status_t;

endpackage : dsa_pkg
`default_nettype wire

@@ sv/dsa_ctrl.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer for the seat allocator: one pick, one division and one write-back
// per seat.
// -----------------------------------------------------------------------------
module dsa_ctrl
  import dsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire dsa_status_t status,
  output dsa_cmd_t         cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PICK,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   done_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = status.seats_zero ? ST_DONE : ST_PICK;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = status.seats_zero ? ST_DONE : ST_PICK;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
      done_r  <= (state_nxt == ST_DONE);
    end
  end

  assign busy = busy_r;
  assign done = done_r;

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("dsa_ctrl: more than one datapath command at once");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy)
    else $error("dsa_ctrl: result strobe while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("dsa_ctrl: accepted word did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("dsa_ctrl: result strobe longer than one cycle");

  a_div_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && status.div_last) |=> cmd.write)
    else $error("dsa_ctrl: division end not followed by write-back");
`endif

endmodule : dsa_ctrl
`default_nettype wire

@@ sv/dsa_datapath.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// dsa_datapath
// Vote, quotient and seat registers, largest-quotient selection and a
// bit-serial restoring divider.
// -----------------------------------------------------------------------------
module dsa_datapath
  import dsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dsa_cmd_t             cmd,
  input  wire vote_vec_t            votes_in,
  input  wire logic [SEAT_IN_W-1:0] seat_total_in,
  output dsa_status_t               status,
  output seat_vec_t                 seats_out
);

  vote_t      votes_r [PARTIES];
  vote_t      quot_r  [PARTIES];
  seat_cnt_t  won_r   [PARTIES];
  seat_cnt_t  left_r;
  party_idx_t best_r;

  vote_t      div_acc_r;
  divisor_t   div_rem_r;
  divisor_t   div_den_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  vote_t      best_val;
  party_idx_t best_idx;
  seat_cnt_t  seat_sat;
  logic [DIVISOR_W:0] div_trial;
  logic       div_take;
  logic       unused_rst;

  // largest quotient, earliest party wins ties
  always_comb begin
    best_val = quot_r[0];
    best_idx = '0;
    for (int p = 1; p < PARTIES; p++) begin
      if (quot_r[p] > best_val) begin
        best_val = quot_r[p];
        best_idx = PIDX_W'(p);
      end
    end
  end

  assign seat_sat = (32'(seat_total_in) > MAX_SEATS) ? SEAT_CNT_W'(MAX_SEATS)
                                                     : SEAT_CNT_W'(seat_total_in);

  // restoring step: bring down the next dividend bit, subtract when it fits
  assign div_trial = {div_rem_r, div_acc_r[VOTE_W-1]};
  assign div_take  = (div_trial >= {1'b0, div_den_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int p = 0; p < PARTIES; p++) begin
        votes_r[p] <= votes_in[p];
        quot_r[p]  <= votes_in[p];
        won_r[p]   <= '0;
      end
      left_r <= seat_sat;
    end
    if (cmd.pick) begin
      best_r <= best_idx;
      for (int p = 0; p < PARTIES; p++) begin
        if (best_idx == PIDX_W'(p)) begin
          won_r[p] <= won_r[p] + 1'b1;
        end
      end
      left_r <= left_r - 1'b1;
    end
    if (cmd.div_load) begin
      div_acc_r <= votes_r[best_r];
      div_rem_r <= '0;
      div_den_r <= DIVISOR_W'(won_r[best_r]) + 1'b1;
      div_cnt_r <= DIV_CNT_W'(VOTE_W);
    end
    if (cmd.div_step) begin
      div_acc_r <= {div_acc_r[VOTE_W-2:0], div_take};
      div_rem_r <= div_take ? DIVISOR_W'(div_trial - {1'b0, div_den_r})
                            : DIVISOR_W'(div_trial);
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (cmd.write) begin
      for (int p = 0; p < PARTIES; p++) begin
        if (best_r == PIDX_W'(p)) begin
          quot_r[p] <= div_acc_r;
        end
      end
    end
  end

  assign unused_rst = rst_n;

  assign status.seats_zero = (left_r == '0) && unused_rst;
  assign status.div_last   = (div_cnt_r == DIV_CNT_W'(1));

  always_comb begin
    for (int p = 0; p < PARTIES; p++) begin
      seats_out[p] = SEAT_OUT_W'(won_r[p]);
    end
  end

endmodule : dsa_datapath
`default_nettype wire

@@ sv/dhondt_seat_allocator_unit.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// dhondt_seat_allocator_unit
// D'Hondt highest-averages seat allocation over five parties.
// -----------------------------------------------------------------------------
// Raise start with the five vote totals and the seat count; the word is taken
// at the clock edge where start is high and busy is low. A seat count above
// 255 is held at 255. Each seat goes to the party with the largest quotient
// (earliest party on a tie), whose quotient then becomes its votes divided by
// its seats won plus one. While a word is worked on busy stays high: every
// seat takes a selection, a divider load, 24 steps of the one-bit-per-cycle
// restoring divider and a write-back. The final seat counts on out_seats_* are
// marked by out_valid, high for a single cycle, the last cycle in which busy is
// high; capture them then, as the unit does not wait for the receiver. The
// counts stay on the ports until the next word is taken.
// -----------------------------------------------------------------------------
module dhondt_seat_allocator_unit
  import dsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VOTE_W-1:0]     in_votes_a,
  input  wire logic [VOTE_W-1:0]     in_votes_b,
  input  wire logic [VOTE_W-1:0]     in_votes_c,
  input  wire logic [VOTE_W-1:0]     in_votes_d,
  input  wire logic [VOTE_W-1:0]     in_votes_e,
  input  wire logic [SEAT_IN_W-1:0]  in_seat_total,
  output logic                       out_valid,
  output logic [SEAT_OUT_W-1:0]      out_seats_a,
  output logic [SEAT_OUT_W-1:0]      out_seats_b,
  output logic [SEAT_OUT_W-1:0]      out_seats_c,
  output logic [SEAT_OUT_W-1:0]      out_seats_d,
  output logic [SEAT_OUT_W-1:0]      out_seats_e
);

  dsa_cmd_t    cmd;
  dsa_status_t status;
  vote_vec_t   votes_in;
  seat_vec_t   seats_out;

  // gather the party totals in order A to E
  assign votes_in[0] = in_votes_a;
  assign votes_in[1] = in_votes_b;
  assign votes_in[2] = in_votes_c;
  assign votes_in[3] = in_votes_d;
  assign votes_in[4] = in_votes_e;

  // sequencer: advance one seat at a time, pulse the strobe at the end
  dsa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  // registers, selection and divider
  dsa_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .votes_in      (votes_in),
    .seat_total_in (in_seat_total),
    .status        (status),
    .seats_out     (seats_out)
  );

  assign out_seats_a = seats_out[0];
  assign out_seats_b = seats_out[1];
  assign out_seats_c = seats_out[2];
  assign out_seats_d = seats_out[3];
  assign out_seats_e = seats_out[4];

endmodule : dhondt_seat_allocator_unit
`default_nettype wire
